// ===== rtl/bimfd_pkg.sv =====
package bimfd_pkg;

    localparam int PRICE_BITS = 32;
    localparam int TIME_BITS  = 63;
    localparam int VOL_BITS   = 48;
    localparam int AMT_BITS   = 56;
    localparam int KIND_BITS  = 2;

    localparam logic [KIND_BITS-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_TOP    = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_BOTTOM = 2'd2;

    localparam logic MARK_TOP    = 1'b0;
    localparam logic MARK_BOTTOM = 1'b1;

    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_ONE   = 2'd1;
    localparam logic [1:0] HELD_THREE = 2'd3;

    localparam logic [1:0] SEEN_TWO = 2'd2;

    typedef logic [PRICE_BITS-1:0] t_price;
    typedef logic [TIME_BITS-1:0]  t_time;
    typedef logic [VOL_BITS-1:0]   t_vol;
    typedef logic [AMT_BITS-1:0]   t_amt;

    typedef struct packed {
        t_time  bar_time;
        t_price bar_open;
        t_price bar_close;
        t_price bar_high;
        t_price bar_low;
        t_vol   bar_volume;
        t_amt   bar_amount;
        logic   falling;    // open above close
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage

// ===== rtl/bar_inclusion_merge_fractal_detect.sv =====
// Bar inclusion merge and fractal detection.
// Input channel: one raw price bar per request (time, open, close, high,
// low, volume, amount), taken when i_in_valid is high and o_in_stall low.
// Output channel: one result per input bar, in order, presented on
// o_out_valid and held while i_out_stall is high. A result carries the
// merged flag, the current merged bar and any top or bottom fractal found.
// A bar accepted into the queue is popped into the output register,
// which drives o_out_valid. Throughput: one bar per cycle while
// i_out_stall is low; the back end updates the held bars on each pop.
// The front end classifies each bar and parks it in a two-entry queue;
// the back end pops the queue whenever its output register is free or
// being drained, and the queue keeps taking bars while a result waits.
// When the receiver stalls, the result holds, the queue fills, and
// o_in_stall rises once both queue entries are occupied.
// Reset (i_rst_n low, synchronous) empties the queue and output register
// and clears all held bars, the fractal count and the last mark.
module bar_inclusion_merge_fractal_detect
    import bimfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_time                i_bar_time,
    input  t_price               i_bar_open,
    input  t_price               i_bar_close,
    input  t_price               i_bar_high,
    input  t_price               i_bar_low,
    input  t_vol                 i_bar_volume,
    input  t_amt                 i_bar_amount,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_merged,
    output t_time                o_out_time,
    output t_price               o_out_open,
    output t_price               o_out_close,
    output t_price               o_out_high,
    output t_price               o_out_low,
    output t_vol                 o_out_volume,
    output t_amt                 o_out_amount,
    output logic [KIND_BITS-1:0] o_fractal_kind,
    output t_time                o_fractal_time,
    output t_price               o_fractal_price
);

    t_head w_head;
    logic  w_pop;

    bimfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_bar_time   (i_bar_time),
        .i_bar_open   (i_bar_open),
        .i_bar_close  (i_bar_close),
        .i_bar_high   (i_bar_high),
        .i_bar_low    (i_bar_low),
        .i_bar_volume (i_bar_volume),
        .i_bar_amount (i_bar_amount),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    bimfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_merged        (o_merged),
        .o_out_time      (o_out_time),
        .o_out_open      (o_out_open),
        .o_out_close     (o_out_close),
        .o_out_high      (o_out_high),
        .o_out_low       (o_out_low),
        .o_out_volume    (o_out_volume),
        .o_out_amount    (o_out_amount),
        .o_fractal_kind  (o_fractal_kind),
        .o_fractal_time  (o_fractal_time),
        .o_fractal_price (o_fractal_price)
    );

    // a merged bar never finalizes a bar, so it cannot report a fractal
    a_merge_no_fractal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_merged) |-> (o_fractal_kind == KIND_NONE))
        else $error("fractal reported on a merged bar");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fractal_kind == KIND_NONE || o_fractal_kind == KIND_TOP ||
                         o_fractal_kind == KIND_BOTTOM))
        else $error("illegal fractal kind");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fractal_kind == KIND_NONE) |->
        (o_fractal_time == '0 && o_fractal_price == '0))
        else $error("fractal fields set without a fractal");

    // the queue pops only into a free or draining output register
    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_head.valid && (!o_out_valid || !i_out_stall)))
        else $error("queue popped without room");

endmodule

// ===== rtl/bimfd_front.sv =====
module bimfd_front
    import bimfd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    input  t_time  i_bar_time,
    input  t_price i_bar_open,
    input  t_price i_bar_close,
    input  t_price i_bar_high,
    input  t_price i_bar_low,
    input  t_vol   i_bar_volume,
    input  t_amt   i_bar_amount,
    output t_head  o_head,
    input  logic   i_pop
);

    t_item      r_slot0;
    t_item      r_slot1;
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       w_push;
    logic       w_pop;
    t_item      w_item;

    assign o_in_stall = r_count[1];
    assign w_push     = i_in_valid && !r_count[1];
    assign w_pop      = i_pop && (r_count != 2'd0);

    always_comb begin
        w_item.bar_time   = i_bar_time;
        w_item.bar_open   = i_bar_open;
        w_item.bar_close  = i_bar_close;
        w_item.bar_high   = i_bar_high;
        w_item.bar_low    = i_bar_low;
        w_item.bar_volume = i_bar_volume;
        w_item.bar_amount = i_bar_amount;
        w_item.falling    = i_bar_open > i_bar_close;
    end

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push && !r_wr_ptr) begin
            r_slot0 <= w_item;
        end
        if (w_push && r_wr_ptr) begin
            r_slot1 <= w_item;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_rd_ptr ? r_slot1 : r_slot0;

endmodule

// ===== rtl/bimfd_back.sv =====
module bimfd_back
    import bimfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_head                i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_merged,
    output t_time                o_out_time,
    output t_price               o_out_open,
    output t_price               o_out_close,
    output t_price               o_out_high,
    output t_price               o_out_low,
    output t_vol                 o_out_volume,
    output t_amt                 o_out_amount,
    output logic [KIND_BITS-1:0] o_fractal_kind,
    output t_time                o_fractal_time,
    output t_price               o_fractal_price
);

    // held bar state
    t_time      r_cur_time;
    t_price     r_cur_open;
    t_price     r_cur_close;
    t_price     r_cur_high;
    t_price     r_cur_low;
    t_vol       r_cur_volume;
    t_amt       r_cur_amount;
    t_price     r_prev_high;
    t_price     r_prev_low;
    t_time      r_prev_time;
    logic [1:0] r_held;
    logic [1:0] r_seen;
    logic       r_last_mark;

    t_time      n_cur_time;
    t_price     n_cur_open;
    t_price     n_cur_close;
    t_price     n_cur_high;
    t_price     n_cur_low;
    t_vol       n_cur_volume;
    t_amt       n_cur_amount;
    t_price     n_prev_high;
    t_price     n_prev_low;
    t_time      n_prev_time;
    logic [1:0] n_held;
    logic [1:0] n_seen;
    logic       n_last_mark;

    // output register
    logic                 r_out_valid;
    logic                 r_merged;
    t_time                r_out_time;
    t_price               r_out_open;
    t_price               r_out_close;
    t_price               r_out_high;
    t_price               r_out_low;
    t_vol                 r_out_volume;
    t_amt                 r_out_amount;
    logic [KIND_BITS-1:0] r_kind;
    t_time                r_ftime;
    t_price               r_fprice;

    logic [KIND_BITS-1:0] n_kind;
    t_time                n_ftime;
    t_price               n_fprice;

    t_item               w_it;
    logic                w_inside;
    logic                w_merge;
    logic                w_up;
    t_price              w_mh;
    t_price              w_ml;
    t_time               w_mt;
    logic [VOL_BITS:0]   w_vsum;
    logic [AMT_BITS:0]   w_asum;
    logic                w_top;
    logic                w_bottom;
    logic                w_mark;
    logic                w_report;

    assign w_it  = i_head.item;
    assign o_pop = i_head.valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        w_inside = (r_cur_high <= w_it.bar_high && r_cur_low >= w_it.bar_low) ||
                   (r_cur_high >= w_it.bar_high && r_cur_low <= w_it.bar_low);
        w_merge  = r_held[1] && (r_prev_high != r_cur_high) && w_inside;
        w_up     = r_prev_high < r_cur_high;

        if (w_up) begin
            w_mh = (r_cur_high > w_it.bar_high) ? r_cur_high : w_it.bar_high;
            w_ml = (r_cur_low > w_it.bar_low) ? r_cur_low : w_it.bar_low;
            w_mt = (r_cur_high > w_it.bar_high) ? r_cur_time : w_it.bar_time;
        end else begin
            w_mh = (r_cur_high < w_it.bar_high) ? r_cur_high : w_it.bar_high;
            w_ml = (r_cur_low < w_it.bar_low) ? r_cur_low : w_it.bar_low;
            w_mt = (r_cur_low < w_it.bar_low) ? r_cur_time : w_it.bar_time;
        end

        w_vsum = {1'b0, r_cur_volume} + {1'b0, w_it.bar_volume};
        w_asum = {1'b0, r_cur_amount} + {1'b0, w_it.bar_amount};

        // after a shift: older = prev, middle = cur, newest = incoming bar
        w_top    = (r_prev_high < r_cur_high) && (r_cur_high > w_it.bar_high) &&
                   (r_prev_low < r_cur_low) && (r_cur_low > w_it.bar_low);
        w_bottom = (r_prev_low > r_cur_low) && (r_cur_low < w_it.bar_low) &&
                   (r_prev_high > r_cur_high) && (r_cur_high < w_it.bar_high);
        w_mark   = w_top ? MARK_TOP : MARK_BOTTOM;

        n_cur_time   = r_cur_time;
        n_cur_open   = r_cur_open;
        n_cur_close  = r_cur_close;
        n_cur_high   = r_cur_high;
        n_cur_low    = r_cur_low;
        n_cur_volume = r_cur_volume;
        n_cur_amount = r_cur_amount;
        n_prev_high  = r_prev_high;
        n_prev_low   = r_prev_low;
        n_prev_time  = r_prev_time;
        n_held       = r_held;
        n_seen       = r_seen;
        n_last_mark  = r_last_mark;
        n_kind       = KIND_NONE;
        n_ftime      = '0;
        n_fprice     = '0;
        w_report     = 1'b0;

        if (w_merge) begin
            n_cur_time   = w_mt;
            n_cur_high   = w_mh;
            n_cur_low    = w_ml;
            n_cur_open   = w_it.falling ? w_mh : w_ml;
            n_cur_close  = w_it.falling ? w_ml : w_mh;
            n_cur_volume = w_vsum[VOL_BITS] ? {VOL_BITS{1'b1}} : w_vsum[VOL_BITS-1:0];
            n_cur_amount = w_asum[AMT_BITS] ? {AMT_BITS{1'b1}} : w_asum[AMT_BITS-1:0];
        end else begin
            if (r_held == HELD_NONE) begin
                n_held = HELD_ONE;
            end else begin
                n_prev_high = r_cur_high;
                n_prev_low  = r_cur_low;
                n_prev_time = r_cur_time;
                if (r_held != HELD_THREE) begin
                    n_held = r_held + 2'd1;
                end
            end
            n_cur_time   = w_it.bar_time;
            n_cur_open   = w_it.bar_open;
            n_cur_close  = w_it.bar_close;
            n_cur_high   = w_it.bar_high;
            n_cur_low    = w_it.bar_low;
            n_cur_volume = w_it.bar_volume;
            n_cur_amount = w_it.bar_amount;

            // drop a repeated mark once two fractals have been reported
            w_report = (n_held == HELD_THREE) && (w_top || w_bottom) &&
                       !((r_seen == SEEN_TWO) && (w_mark == r_last_mark));
            if (w_report) begin
                n_kind      = w_top ? KIND_TOP : KIND_BOTTOM;
                n_ftime     = r_cur_time;
                n_fprice    = w_top ? r_cur_high : r_cur_low;
                n_last_mark = w_mark;
                if (r_seen != SEEN_TWO) begin
                    n_seen = r_seen + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_time   <= '0;
            r_cur_open   <= '0;
            r_cur_close  <= '0;
            r_cur_high   <= '0;
            r_cur_low    <= '0;
            r_cur_volume <= '0;
            r_cur_amount <= '0;
            r_prev_high  <= '0;
            r_prev_low   <= '0;
            r_prev_time  <= '0;
            r_held       <= HELD_NONE;
            r_seen       <= 2'd0;
            r_last_mark  <= MARK_TOP;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= o_pop || (r_out_valid && i_out_stall);
            if (o_pop) begin
                r_cur_time   <= n_cur_time;
                r_cur_open   <= n_cur_open;
                r_cur_close  <= n_cur_close;
                r_cur_high   <= n_cur_high;
                r_cur_low    <= n_cur_low;
                r_cur_volume <= n_cur_volume;
                r_cur_amount <= n_cur_amount;
                r_prev_high  <= n_prev_high;
                r_prev_low   <= n_prev_low;
                r_prev_time  <= n_prev_time;
                r_held       <= n_held;
                r_seen       <= n_seen;
                r_last_mark  <= n_last_mark;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_merged     <= w_merge;
            r_out_time   <= n_cur_time;
            r_out_open   <= n_cur_open;
            r_out_close  <= n_cur_close;
            r_out_high   <= n_cur_high;
            r_out_low    <= n_cur_low;
            r_out_volume <= n_cur_volume;
            r_out_amount <= n_cur_amount;
            r_kind       <= n_kind;
            r_ftime      <= n_ftime;
            r_fprice     <= n_fprice;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_merged        = r_merged;
    assign o_out_time      = r_out_time;
    assign o_out_open      = r_out_open;
    assign o_out_close     = r_out_close;
    assign o_out_high      = r_out_high;
    assign o_out_low       = r_out_low;
    assign o_out_volume    = r_out_volume;
    assign o_out_amount    = r_out_amount;
    assign o_fractal_kind  = r_kind;
    assign o_fractal_time  = r_ftime;
    assign o_fractal_price = r_fprice;

endmodule

// ===== dv/bar_inclusion_merge_fractal_detect_tb.sv =====
`timescale 1ns / 1ps

module bar_inclusion_merge_fractal_detect_tb
    import bimfd_pkg::*;
();

    localparam int N_DIR          = 16;
    localparam int N_RAND         = 1434;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SQUEEZE_AT     = 500;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_CAP     = 100;

    localparam t_time  TIME_TOP  = '1;
    localparam t_price PRICE_TOP = '1;
    localparam t_vol   VOL_TOP   = '1;
    localparam t_amt   AMT_TOP   = '1;

    typedef struct packed {
        t_time  tm;
        t_price op;
        t_price cl;
        t_price hi;
        t_price lo;
        t_vol   vol;
        t_amt   amt;
    } t_bar;

    typedef struct packed {
        logic                 merged;
        t_time                tm;
        t_price               op;
        t_price               cl;
        t_price               hi;
        t_price               lo;
        t_vol                 vol;
        t_amt                 amt;
        logic [KIND_BITS-1:0] kind;
        t_time                ftm;
        t_price               fpx;
    } t_res;

    typedef struct packed {
        t_bar bar;
        logic fixed;
        t_res res;
    } t_row;

    logic   i_clk       = 1'b0;
    logic   i_rst_n     = 1'b0;
    logic   i_in_valid  = 1'b0;
    logic   i_out_stall = 1'b0;
    t_bar   drv         = '0;
    logic   row_fixed   = 1'b0;
    t_res   row_res     = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_merged;
    t_time                o_out_time;
    t_price               o_out_open;
    t_price               o_out_close;
    t_price               o_out_high;
    t_price               o_out_low;
    t_vol                 o_out_volume;
    t_amt                 o_out_amount;
    logic [KIND_BITS-1:0] o_fractal_kind;
    t_time                o_fractal_time;
    t_price               o_fractal_price;

    // predictor copy of the held bars
    t_time  cur_time;
    t_price cur_open, cur_close, cur_high, cur_low;
    t_vol   cur_vol;
    t_amt   cur_amt;
    t_price fin_high, fin_low, old_high, old_low;
    t_time  fin_time;
    logic [1:0] held;
    logic [1:0] seen;
    logic       last_mark;

    t_res   due_results [$];
    int     mismatches = 0;
    int     bars_taken = 0;
    int     quiet      = 0;

    // random bar walk
    longint walk_hi, walk_lo;
    int     seg_left = 0;
    t_time  bar_clock;

    t_row   dir_tab [N_DIR];

    always #5 i_clk = ~i_clk;

    bar_inclusion_merge_fractal_detect u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_bar_time     (drv.tm),
        .i_bar_open     (drv.op),
        .i_bar_close    (drv.cl),
        .i_bar_high     (drv.hi),
        .i_bar_low      (drv.lo),
        .i_bar_volume   (drv.vol),
        .i_bar_amount   (drv.amt),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_merged       (o_merged),
        .o_out_time     (o_out_time),
        .o_out_open     (o_out_open),
        .o_out_close    (o_out_close),
        .o_out_high     (o_out_high),
        .o_out_low      (o_out_low),
        .o_out_volume   (o_out_volume),
        .o_out_amount   (o_out_amount),
        .o_fractal_kind (o_fractal_kind),
        .o_fractal_time (o_fractal_time),
        .o_fractal_price(o_fractal_price)
    );

    task automatic clear_held_bars();
        cur_time  = '0;
        cur_open  = '0;
        cur_close = '0;
        cur_high  = '0;
        cur_low   = '0;
        cur_vol   = '0;
        cur_amt   = '0;
        fin_high  = '0;
        fin_low   = '0;
        fin_time  = '0;
        old_high  = '0;
        old_low   = '0;
        held      = HELD_NONE;
        seen      = '0;
        last_mark = MARK_TOP;
    endtask

    // Merge or finalize one raw bar and report the fractal that a shift exposes.
    task automatic fold_bar(input t_bar b, output t_res r);
        logic              take;
        logic              found;
        logic              mk;
        t_price            nh, nl;
        t_time             nt;
        logic [VOL_BITS:0] vol_sum;
        logic [AMT_BITS:0] amt_sum;
        take  = 1'b0;
        found = 1'b0;
        mk    = MARK_TOP;
        r     = '0;
        if (held >= 2'd2 && fin_high != cur_high &&
            ((cur_high <= b.hi && cur_low >= b.lo) ||
             (cur_high >= b.hi && cur_low <= b.lo))) begin
            if (fin_high < cur_high) begin
                nh = (cur_high > b.hi) ? cur_high : b.hi;
                nl = (cur_low > b.lo) ? cur_low : b.lo;
                nt = (cur_high > b.hi) ? cur_time : b.tm;
            end else begin
                nh = (cur_high < b.hi) ? cur_high : b.hi;
                nl = (cur_low < b.lo) ? cur_low : b.lo;
                nt = (cur_low < b.lo) ? cur_time : b.tm;
            end
            cur_time = nt;
            cur_high = nh;
            cur_low  = nl;
            if (b.op > b.cl) begin
                cur_open  = nh;
                cur_close = nl;
            end else begin
                cur_open  = nl;
                cur_close = nh;
            end
            vol_sum = {1'b0, cur_vol} + {1'b0, b.vol};
            amt_sum = {1'b0, cur_amt} + {1'b0, b.amt};
            cur_vol = vol_sum[VOL_BITS] ? VOL_TOP : vol_sum[VOL_BITS-1:0];
            cur_amt = amt_sum[AMT_BITS] ? AMT_TOP : amt_sum[AMT_BITS-1:0];
            take    = 1'b1;
        end
        if (!take) begin
            if (held == HELD_NONE) begin
                held = HELD_ONE;
            end else begin
                old_high = fin_high;
                old_low  = fin_low;
                fin_high = cur_high;
                fin_low  = cur_low;
                fin_time = cur_time;
                if (held != HELD_THREE)
                    held = held + 2'd1;
            end
            cur_time  = b.tm;
            cur_open  = b.op;
            cur_close = b.cl;
            cur_high  = b.hi;
            cur_low   = b.lo;
            cur_vol   = b.vol;
            cur_amt   = b.amt;
            if (held == HELD_THREE) begin
                if (old_high < fin_high && fin_high > cur_high &&
                    old_low < fin_low && fin_low > cur_low) begin
                    found = 1'b1;
                    mk    = MARK_TOP;
                end else if (old_low > fin_low && fin_low < cur_low &&
                             old_high > fin_high && fin_high < cur_high) begin
                    found = 1'b1;
                    mk    = MARK_BOTTOM;
                end
                // drop a repeated mark once two fractals are on record
                if (found && !(seen >= SEEN_TWO && mk == last_mark)) begin
                    r.kind    = (mk == MARK_TOP) ? KIND_TOP : KIND_BOTTOM;
                    r.ftm     = fin_time;
                    r.fpx     = (mk == MARK_TOP) ? fin_high : fin_low;
                    last_mark = mk;
                    if (seen != SEEN_TWO)
                        seen = seen + 2'd1;
                end
            end
        end
        r.merged = take;
        r.tm     = cur_time;
        r.op     = cur_open;
        r.cl     = cur_close;
        r.hi     = cur_high;
        r.lo     = cur_low;
        r.vol    = cur_vol;
        r.amt    = cur_amt;
    endtask

    function automatic longint clamp_price(input longint p);
        if (p < 0)
            return 0;
        if (p > longint'(PRICE_TOP))
            return longint'(PRICE_TOP);
        return p;
    endfunction

    // Mostly bars that step, nest or engulf the last one; some pure noise.
    task automatic make_bar(output t_bar b);
        int     pick;
        longint span, h, l;
        if (seg_left == 0) begin
            seg_left = $urandom_range(20, 150);
            case ($urandom_range(0, 3))
                0: walk_lo = longint'($urandom_range(0, 16));
                1: walk_lo = longint'(PRICE_TOP) - $urandom_range(0, 40);
                default: walk_lo = longint'($urandom_range(1000, 32'h7FFF_FFFF));
            endcase
            walk_hi = clamp_price(walk_lo + $urandom_range(0, 12));
        end
        seg_left--;
        span = walk_hi - walk_lo;
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            h = walk_hi - $urandom_range(0, int'(span / 2));
            l = walk_lo + $urandom_range(0, int'(span / 2));
        end else if (pick < 34) begin
            h = walk_hi + $urandom_range(0, 5);
            l = walk_lo - $urandom_range(0, 5);
        end else if (pick < 60) begin
            h = walk_hi + $urandom_range(1, 8);
            l = walk_lo + $urandom_range(1, 8);
        end else if (pick < 86) begin
            h = walk_hi - $urandom_range(1, 8);
            l = walk_lo - $urandom_range(1, 8);
        end else if (pick < 92) begin
            h = walk_hi;
            l = walk_lo + $urandom_range(0, 4) - 2;
        end else begin
            b.tm  = t_time'({$urandom, $urandom});
            b.op  = $urandom;
            b.cl  = $urandom;
            b.hi  = $urandom;
            b.lo  = $urandom;
            b.vol = t_vol'({$urandom, $urandom});
            b.amt = t_amt'({$urandom, $urandom});
            return;
        end
        h = clamp_price(h);
        l = clamp_price(l);
        if (l > h)
            l = h;
        walk_hi = h;
        walk_lo = l;
        bar_clock = bar_clock + $urandom_range(1, 60);
        b.tm = bar_clock;
        b.hi = t_price'(h);
        b.lo = t_price'(l);
        b.op = $urandom_range(t_price'(l), t_price'(h));
        b.cl = $urandom_range(t_price'(l), t_price'(h));
        case ($urandom_range(0, 9))
            0: b.vol = VOL_TOP - t_vol'($urandom_range(0, 3));
            1, 2: b.vol = t_vol'({$urandom, $urandom});
            default: b.vol = t_vol'($urandom_range(0, 5000));
        endcase
        case ($urandom_range(0, 9))
            0: b.amt = AMT_TOP - t_amt'($urandom_range(0, 3));
            1, 2: b.amt = t_amt'({$urandom, $urandom});
            default: b.amt = t_amt'($urandom_range(0, 500000));
        endcase
    endtask

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // both sides run flat out through this stretch
    function automatic logic in_quiet_stretch();
        return (bars_taken / 150) % 4 == 2;
    endfunction

    task automatic send_bar(input t_bar b, input logic fx, input t_res fr);
        int gap;
        gap = in_quiet_stretch() ? 0 : pick_pause();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        drv        <= b;
        row_fixed  <= fx;
        row_res    <= fr;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            // quiet after the first hundred
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_res want;
        t_res guess;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request pending, expected none, actual time %0h",
                             $time, o_out_time);
                end else begin
                    want = due_results.pop_front();
                    check_field("merged", 64'(want.merged), 64'(o_merged));
                    check_field("out_time", 64'(want.tm), 64'(o_out_time));
                    check_field("out_open", 64'(want.op), 64'(o_out_open));
                    check_field("out_close", 64'(want.cl), 64'(o_out_close));
                    check_field("out_high", 64'(want.hi), 64'(o_out_high));
                    check_field("out_low", 64'(want.lo), 64'(o_out_low));
                    check_field("out_volume", 64'(want.vol), 64'(o_out_volume));
                    check_field("out_amount", 64'(want.amt), 64'(o_out_amount));
                    check_field("fractal_kind", 64'(want.kind), 64'(o_fractal_kind));
                    check_field("fractal_time", 64'(want.ftm), 64'(o_fractal_time));
                    check_field("fractal_price", 64'(want.fpx), 64'(o_fractal_price));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                fold_bar(drv, guess);
                due_results.insert(due_results.size(), row_fixed ? row_res : guess);
                bars_taken++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet <= 0;
        end else if (quiet == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : result_stall
        int  hold;
        logic squeezed;
        squeezed = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!squeezed && bars_taken >= SQUEEZE_AT) begin
                // hold off long enough to back the block up into its input
                squeezed    = 1'b1;
                hold        = SQUEEZE_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                hold        = in_quiet_stretch() ? 0 : pick_pause();
                i_out_stall <= (hold != 0);
                if (hold == 0)
                    hold = $urandom_range(1, 6);
            end
            repeat (hold - 1) @(negedge i_clk);
        end
    end

    initial begin : bar_feed
        t_bar b;
        // first two rows follow straight from reset: no bar held, then one held
        dir_tab[0]  = '{'{63'd1, 32'd100, 32'd200, 32'd300, 32'd50, VOL_TOP, AMT_TOP}, 1'b1,
                        '{1'b0, 63'd1, 32'd100, 32'd200, 32'd300, 32'd50, VOL_TOP, AMT_TOP,
                          KIND_NONE, 63'd0, 32'd0}};
        dir_tab[1]  = '{'{63'd2, 32'd250, 32'd150, 32'd300, 32'd100, 48'd3, 56'd4}, 1'b1,
                        '{1'b0, 63'd2, 32'd250, 32'd150, 32'd300, 32'd100, 48'd3, 56'd4,
                          KIND_NONE, 63'd0, 32'd0}};
        // equal highs: inside but not merged
        dir_tab[2]  = '{'{63'd3, 32'd90, 32'd280, 32'd300, 32'd80, 48'd10, 56'd20}, 1'b0, '0};
        dir_tab[3]  = '{'{63'd4, 32'd240, 32'd70, 32'd250, 32'd60, VOL_TOP, AMT_TOP}, 1'b0, '0};
        // down merges, both time choices, saturating sums
        dir_tab[4]  = '{'{63'd5, 32'd200, 32'd120, 32'd260, 32'd50, 48'd5, 56'd7}, 1'b0, '0};
        dir_tab[5]  = '{'{63'd6, 32'd100, 32'd110, 32'd240, 32'd55, 48'd1, 56'd1}, 1'b0, '0};
        dir_tab[6]  = '{'{63'd7, 32'd210, 32'd390, 32'd400, 32'd200, 48'd40, 56'd400}, 1'b0, '0};
        // up merges, both time choices
        dir_tab[7]  = '{'{63'd8, 32'd480, 32'd160, 32'd500, 32'd150, 48'd30, 56'd300}, 1'b0, '0};
        dir_tab[8]  = '{'{63'd9, 32'd310, 32'd440, 32'd450, 32'd300, 48'd20, 56'd200}, 1'b0, '0};
        dir_tab[9]  = '{'{63'd10, 32'd400, 32'd260, 32'd450, 32'd250, 48'd0, 56'd0}, 1'b0, '0};
        dir_tab[10] = '{'{63'd11, 32'd190, 32'd110, 32'd200, 32'd100, 48'd6, 56'd9}, 1'b0, '0};
        dir_tab[11] = '{'{63'd12, 32'd160, 32'd290, 32'd300, 32'd150, 48'd8, 56'd3}, 1'b0, '0};
        // field extremes, then a top fractal on the extreme bar
        dir_tab[12] = '{'{TIME_TOP, 32'd0, PRICE_TOP, PRICE_TOP, 32'hFFFF_0000, VOL_TOP, AMT_TOP},
                        1'b0, '0};
        dir_tab[13] = '{'{63'd0, PRICE_TOP, 32'd0, 32'd0, 32'd0, 48'd0, 56'd0}, 1'b0, '0};
        dir_tab[14] = '{'{63'd15, 32'd10, 32'd0, 32'd10, 32'd0, 48'd2, 56'd2}, 1'b0, '0};
        // high below low
        dir_tab[15] = '{'{63'd16, 32'd5, 32'd6, 32'd3, 32'd9, 48'd1, 56'd1}, 1'b0, '0};

        clear_held_bars();
        bar_clock = t_time'({$urandom, $urandom});
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIR; k++)
            send_bar(dir_tab[k].bar, dir_tab[k].fixed, dir_tab[k].res);
        for (int k = 0; k < N_RAND; k++) begin
            make_bar(b);
            send_bar(b, 1'b0, '0);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
